>>> rtl/core/palette_gradient_table_generator_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the palette gradient table generator
// Wraps concurrent assertions so that they vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef PALETTE_GRADIENT_TABLE_GENERATOR_CORE_DEFINES_SVH
`define PALETTE_GRADIENT_TABLE_GENERATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst is high.
`define PGTG_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk, off while rst is high.
`define PGTG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PGTG_ASSERT_IMPLY(label, ante, cons, msg)
`define PGTG_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> rtl/core/pgtg_pkg.sv
// ----------------------------------------------------------------------------
// Palette gradient table generator package
// Shared widths, register indexes, reset values and the blend request type.
// ----------------------------------------------------------------------------
`default_nettype none

package pgtg_pkg;

  localparam int MAX_ENTRIES_DEFAULT = 16;

  localparam int CH_W      = 5;
  localparam int COLOR_W   = 15;
  localparam int INDEX_W   = 8;
  localparam int HEIGHT_W  = 8;
  localparam int ALPHA_W   = 6;
  localparam int COUNT_W   = 5;
  localparam int QUO_W     = 6;
  localparam int DIV_STEPS = 6;
  localparam int FRAC_W    = 5;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 15;

  localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_START   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_COUNT     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TINT_COLOR      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BLEND_ALPHA     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GRADIENT_HEIGHT = 3'd4;

  localparam logic [INDEX_W-1:0]  RST_PALETTE_START   = 8'd0;
  localparam logic [COUNT_W-1:0]  RST_ENTRY_COUNT     = 5'd4;
  localparam logic [COLOR_W-1:0]  RST_TINT_COLOR      = 15'd0;
  localparam logic [ALPHA_W-1:0]  RST_BLEND_ALPHA     = 6'd26;
  localparam logic [HEIGHT_W-1:0] RST_GRADIENT_HEIGHT = 8'd224;

  // Full blend weight (1.0 in 1/32 steps) and the channel ceiling.
  localparam logic [ALPHA_W-1:0] WEIGHT_ONE = 6'd32;
  localparam logic [CH_W-1:0]    CH_MAX     = 5'd31;

  // The restore pass runs only while height + entries stays below this.
  localparam int RESTORE_LIMIT = 223;

  typedef struct packed {
    logic [HEIGHT_W-1:0] diff;
    logic [HEIGHT_W-1:0] height;
    logic [ALPHA_W-1:0]  alpha;
    logic [COLOR_W-1:0]  base;
    logic [COLOR_W-1:0]  target;
  } blend_req_t;

endpackage

`default_nettype wire

>>> rtl/core/pgtg_blend_unit.sv
// ----------------------------------------------------------------------------
// Gradient blend unit
// Serial divide of the position fraction, weight product, then one RGB555
// channel blended per cycle on a shared pair of small multipliers.
// ----------------------------------------------------------------------------
`default_nettype none

module pgtg_blend_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire pgtg_pkg::blend_req_t             req,
  output logic                                  done,
  output logic [pgtg_pkg::COLOR_W-1:0]          color
);

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_DIV  = 2'd1;
  localparam logic [1:0] U_WGT  = 2'd2;
  localparam logic [1:0] U_MIX  = 2'd3;

  localparam int REM_W = pgtg_pkg::HEIGHT_W + pgtg_pkg::FRAC_W;
  localparam int PRD_W = 2 * pgtg_pkg::ALPHA_W;
  localparam int SUM_W = pgtg_pkg::CH_W + pgtg_pkg::ALPHA_W + 1;
  localparam logic [2:0] DIV_LAST = 3'(pgtg_pkg::DIV_STEPS - 1);
  localparam logic [2:0] MIX_LAST = 3'd2;

  logic [1:0]                       u_state;
  logic [REM_W-1:0]                 rem;
  logic [REM_W-1:0]                 dvs;
  logic [pgtg_pkg::QUO_W-1:0]       quo;
  logic [2:0]                       step;
  logic [pgtg_pkg::ALPHA_W-1:0]     alpha;
  logic [pgtg_pkg::ALPHA_W-1:0]     w1;
  logic [pgtg_pkg::ALPHA_W-1:0]     w2;
  logic [pgtg_pkg::COLOR_W-1:0]     base_sh;
  logic [pgtg_pkg::COLOR_W-1:0]     tgt_sh;
  logic [pgtg_pkg::COLOR_W-1:0]     acc;

  logic                             ge;
  logic [PRD_W-1:0]                 prod;
  logic [pgtg_pkg::ALPHA_W-1:0]     w2_calc;
  logic [SUM_W-1:0]                 sum;
  logic [pgtg_pkg::ALPHA_W-1:0]     mixed;
  logic [pgtg_pkg::CH_W-1:0]        ch_sat;

  always_comb begin
    ge      = (rem >= dvs);
    prod    = PRD_W'(pgtg_pkg::WEIGHT_ONE - quo) * PRD_W'(alpha);
    w2_calc = prod[pgtg_pkg::FRAC_W +: pgtg_pkg::ALPHA_W];
    sum     = SUM_W'(base_sh[pgtg_pkg::CH_W-1:0]) * SUM_W'(w1)
            + SUM_W'(tgt_sh[pgtg_pkg::CH_W-1:0]) * SUM_W'(w2);
    mixed   = sum[pgtg_pkg::FRAC_W +: pgtg_pkg::ALPHA_W];
    ch_sat  = (mixed > pgtg_pkg::ALPHA_W'(pgtg_pkg::CH_MAX)) ? pgtg_pkg::CH_MAX
                                                            : mixed[pgtg_pkg::CH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      u_state <= U_IDLE;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (u_state)
        U_IDLE: begin
          if (start) begin
            u_state <= U_DIV;
          end
        end
        U_DIV: begin
          if (step == DIV_LAST) begin
            u_state <= U_WGT;
          end
        end
        U_WGT: begin
          u_state <= U_MIX;
        end
        U_MIX: begin
          if (step == MIX_LAST) begin
            u_state <= U_IDLE;
            done    <= 1'b1;
          end
        end
        default: begin
          u_state <= U_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (u_state)
      U_IDLE: begin
        if (start) begin
          rem     <= {req.diff, pgtg_pkg::FRAC_W'(0)};
          dvs     <= {req.height, pgtg_pkg::FRAC_W'(0)};
          quo     <= '0;
          step    <= '0;
          alpha   <= (req.alpha > pgtg_pkg::WEIGHT_ONE) ? pgtg_pkg::WEIGHT_ONE : req.alpha;
          base_sh <= req.base;
          tgt_sh  <= req.target;
        end
      end
      U_DIV: begin
        if (ge) begin
          rem <= rem - dvs;
        end
        quo  <= {quo[pgtg_pkg::QUO_W-2:0], ge};
        dvs  <= dvs >> 1;
        step <= step + 3'd1;
      end
      U_WGT: begin
        w2   <= w2_calc;
        w1   <= pgtg_pkg::WEIGHT_ONE - w2_calc;
        step <= '0;
      end
      U_MIX: begin
        acc     <= {ch_sat, acc[pgtg_pkg::COLOR_W-1:pgtg_pkg::CH_W]};
        base_sh <= base_sh >> pgtg_pkg::CH_W;
        tgt_sh  <= tgt_sh >> pgtg_pkg::CH_W;
        step    <= step + 3'd1;
      end
      default: begin
        step <= '0;
      end
    endcase
  end

  assign color = acc;

endmodule

`default_nettype wire

>>> rtl/core/palette_gradient_table_generator_core.sv
// ----------------------------------------------------------------------------
// Palette gradient table generator core
// A blend entry passes from acceptance through 6 divide steps, one weight
// product and 3 channel mixes on the shared blend unit; then the unit's result
// is taken and the output register loaded. The next item is taken only once
// the result has moved to the output register. A restore entry skips the blend
// unit and goes straight to the waiting result, then to the output register;
// an item after the table is done is accepted and produces nothing.
// A result that finds the output register full waits there and holds the input.
// Reset (rst, synchronous) restores register defaults and the table start.
// ----------------------------------------------------------------------------
`default_nettype none
`include "palette_gradient_table_generator_core_defines.svh"

module palette_gradient_table_generator_core #(
  parameter int MAX_ENTRIES = pgtg_pkg::MAX_ENTRIES_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Configuration write channel.
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [pgtg_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [pgtg_pkg::CFG_DATA_W-1:0]     cfg_data,
  // Input stream.
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [15:0]                         s_tdata,  // [14:0] base_color
  input  wire logic                                s_tuser,  // [0] restart
  // Result stream.
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [23:0]                              m_tdata,  // [7:0] cgram_index,
                                                             // [22:8] color
  output logic                                     m_tuser,  // [0] is_restore
  output logic                                     m_tlast   // last
);

  // The entry counter holds values below MAX_ENTRIES. Entry arithmetic runs
  // one bit wider so that counter + 1 and the entry count itself both fit,
  // and never narrower than the entry count register.
  localparam int CW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int EW = (CW + 1 > pgtg_pkg::COUNT_W) ? CW + 1 : pgtg_pkg::COUNT_W;
  // The restore test adds height and entries, so it needs one bit over the
  // wider of the two.
  localparam int LW = ((EW > pgtg_pkg::HEIGHT_W) ? EW : pgtg_pkg::HEIGHT_W) + 1;

  localparam logic [1:0] PH_BLEND   = 2'd0;
  localparam logic [1:0] PH_RESTORE = 2'd1;
  localparam logic [1:0] PH_DONE    = 2'd2;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_BLEND = 2'd1;
  localparam logic [1:0] ST_FIN   = 2'd2;

  // Configuration registers.
  logic [pgtg_pkg::INDEX_W-1:0]  palette_start;
  logic [pgtg_pkg::COUNT_W-1:0]  entry_count;
  logic [pgtg_pkg::COLOR_W-1:0]  tint_color;
  logic [pgtg_pkg::ALPHA_W-1:0]  blend_alpha;
  logic [pgtg_pkg::HEIGHT_W-1:0] gradient_height;

  // Table walk state.
  logic [1:0]                    phase;
  logic [pgtg_pkg::HEIGHT_W-1:0] line_position;
  logic [CW-1:0]                 entry_counter;
  logic [1:0]                    state;

  // Result waiting for the output register.
  logic [pgtg_pkg::INDEX_W-1:0]  res_index;
  logic [pgtg_pkg::COLOR_W-1:0]  res_color;
  logic                          res_restore;
  logic                          res_last;

  // Next-state decode for the item being accepted.
  logic                          accept;
  logic [EW-1:0]                 entries;
  logic                          restore_ok;
  logic [1:0]                    phase_cur;
  logic [pgtg_pkg::HEIGHT_W-1:0] pos_cur;
  logic [CW-1:0]                 cnt_cur;
  logic [1:0]                    phase_next;
  logic [pgtg_pkg::HEIGHT_W-1:0] line_position_next;
  logic [CW-1:0]                 entry_counter_next;
  logic                          item_last;
  logic [pgtg_pkg::HEIGHT_W-1:0] diff;
  logic                          cnt_wrap;
  logic                          pos_end;

  pgtg_pkg::blend_req_t          blend_req;
  logic                          blend_start;
  logic                          blend_done;
  logic [pgtg_pkg::COLOR_W-1:0]  blend_color;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;

  // Effective entry count: zero counts as one, and it never exceeds the
  // counter's depth.
  always_comb begin
    if (entry_count == '0) begin
      entries = EW'(1);
    end else if (EW'(entry_count) > EW'(MAX_ENTRIES)) begin
      entries = EW'(MAX_ENTRIES);
    end else begin
      entries = EW'(entry_count);
    end
    restore_ok = (LW'(gradient_height) + LW'(entries)) < LW'(pgtg_pkg::RESTORE_LIMIT);
  end

  // Work out where the accepted item lands in the table. A restart clears the
  // walk first. An empty gradient skips straight to the restore pass or ends.
  always_comb begin
    phase_cur = s_tuser ? PH_BLEND : phase;
    pos_cur   = s_tuser ? '0 : line_position;
    cnt_cur   = s_tuser ? '0 : entry_counter;
    if ((phase_cur == PH_BLEND) && (gradient_height == '0)) begin
      cnt_cur   = '0;
      phase_cur = restore_ok ? PH_RESTORE : PH_DONE;
    end

    cnt_wrap = (EW'(cnt_cur) + EW'(1)) >= entries;
    pos_end  = ((pgtg_pkg::HEIGHT_W + 1)'(pos_cur) + 9'd1)
               >= (pgtg_pkg::HEIGHT_W + 1)'(gradient_height);
    diff     = (pos_cur < gradient_height) ? gradient_height - pos_cur : '0;

    phase_next         = phase_cur;
    line_position_next = pos_cur;
    entry_counter_next = cnt_cur;
    item_last          = 1'b0;

    case (phase_cur)
      PH_BLEND: begin
        if (pos_end) begin
          entry_counter_next = '0;
          line_position_next = '0;
          phase_next         = restore_ok ? PH_RESTORE : PH_DONE;
          item_last          = !restore_ok;
        end else begin
          line_position_next = pos_cur + 8'd1;
          entry_counter_next = cnt_wrap ? '0 : cnt_cur + CW'(1);
        end
      end
      PH_RESTORE: begin
        item_last = cnt_wrap;
        if (cnt_wrap) begin
          entry_counter_next = '0;
          phase_next         = PH_DONE;
        end else begin
          entry_counter_next = cnt_cur + CW'(1);
        end
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase
  end

  always_comb begin
    blend_req.diff   = diff;
    blend_req.height = gradient_height;
    blend_req.alpha  = blend_alpha;
    blend_req.base   = s_tdata[pgtg_pkg::COLOR_W-1:0];
    blend_req.target = tint_color;
  end

  assign blend_start = accept && (phase_cur == PH_BLEND);

  pgtg_blend_unit u_blend (
    .clk   (clk),
    .rst   (rst),
    .start (blend_start),
    .req   (blend_req),
    .done  (blend_done),
    .color (blend_color)
  );

  // Control state: configuration, table walk, sequencer and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      palette_start   <= pgtg_pkg::RST_PALETTE_START;
      entry_count     <= pgtg_pkg::RST_ENTRY_COUNT;
      tint_color      <= pgtg_pkg::RST_TINT_COLOR;
      blend_alpha     <= pgtg_pkg::RST_BLEND_ALPHA;
      gradient_height <= pgtg_pkg::RST_GRADIENT_HEIGHT;
      phase           <= PH_BLEND;
      line_position   <= '0;
      entry_counter   <= '0;
      state           <= ST_IDLE;
      m_tvalid        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pgtg_pkg::REG_PALETTE_START:
            palette_start <= cfg_data[pgtg_pkg::INDEX_W-1:0];
          pgtg_pkg::REG_ENTRY_COUNT:
            entry_count <= cfg_data[pgtg_pkg::COUNT_W-1:0];
          pgtg_pkg::REG_TINT_COLOR:
            tint_color <= cfg_data[pgtg_pkg::COLOR_W-1:0];
          pgtg_pkg::REG_BLEND_ALPHA:
            blend_alpha <= cfg_data[pgtg_pkg::ALPHA_W-1:0];
          pgtg_pkg::REG_GRADIENT_HEIGHT:
            gradient_height <= cfg_data[pgtg_pkg::HEIGHT_W-1:0];
          default: begin
          end
        endcase
      end

      // The output register empties on a transaction and refills from a
      // waiting result in the same cycle when there is one.
      if ((state == ST_FIN) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            phase         <= phase_next;
            line_position <= line_position_next;
            entry_counter <= entry_counter_next;
            if (phase_cur == PH_BLEND) begin
              state <= ST_BLEND;
            end else if (phase_cur == PH_RESTORE) begin
              state <= ST_FIN;
            end
          end
        end
        ST_BLEND: begin
          if (blend_done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          // Hand the result over as soon as the output register is free.
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && accept) begin
      res_index   <= palette_start + pgtg_pkg::INDEX_W'(cnt_cur);
      res_color   <= s_tdata[pgtg_pkg::COLOR_W-1:0];
      res_restore <= (phase_cur == PH_RESTORE);
      res_last    <= item_last;
    end else if ((state == ST_BLEND) && blend_done) begin
      res_color <= blend_color;
    end
    if ((state == ST_FIN) && (!m_tvalid || m_tready)) begin
      m_tdata <= {1'b0, res_color, res_index};
      m_tuser <= res_restore;
      m_tlast <= res_last;
    end
  end

  // The blend unit only finishes while the sequencer waits on it.
  `PGTG_ASSERT_IMPLY(a_done_in_blend, blend_done, state == ST_BLEND,
                     "blend unit finished outside the blend wait")
  // A result meeting a free output register is handed over on the next edge.
  `PGTG_ASSERT_NEXT(a_fin_hands_over, (state == ST_FIN) && !m_tvalid,
                    m_tvalid && (state == ST_IDLE),
                    "result held while the output register was free")
  // The blend result is a single-cycle strobe.
  `PGTG_ASSERT_NEXT(a_done_pulse, blend_done, !blend_done,
                    "blend done held for more than one cycle")
  // Starting a blend always moves the sequencer off idle.
  `PGTG_ASSERT_NEXT(a_start_leaves_idle, blend_start, state == ST_BLEND,
                    "blend started but the sequencer did not wait on it")

endmodule

`default_nettype wire

>>> sim/tb_palette_gradient_table_generator_core.sv
// ----------------------------------------------------------------------------
// Testbench for the palette gradient table generator core
// Drives base colors through the input stream and checks every table entry
// against an in-bench model of the blend and restore walk or a typed-in entry. A short stimulus
// table covers the extremes, then random table walks run under several
// idling patterns and one long output stall.
// ----------------------------------------------------------------------------
module tb_palette_gradient_table_generator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ENTRIES      = pgtg_pkg::MAX_ENTRIES_DEFAULT;
  localparam int RESET_CYCLES     = 9;
  // Long enough for a blend entry and any item still in flight.
  localparam int SETTLE_CYCLES    = 16;
  localparam int QUIET_LIMIT      = 3000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int TARGET_ITEMS     = 1700;
  localparam int PHASE_COUNT      = 8;

  typedef enum logic [1:0] {TBL_BLEND, TBL_RESTORE, TBL_DONE} table_phase_t;

  // One table entry as it leaves the block.
  typedef struct packed {
    logic [pgtg_pkg::INDEX_W-1:0] cgram_index;
    logic [pgtg_pkg::COLOR_W-1:0] color;
    logic                         is_restore;
    logic                         last;
  } table_entry_t;

  // Rows of the directed table: a register write, an item checked against the
  // model, an item with its entry typed in, or an item that must stay silent.
  typedef enum logic [1:0] {ROW_WRITE, ROW_PREDICT, ROW_GIVEN, ROW_SILENT} row_kind_t;

  typedef struct packed {
    row_kind_t                        kind;
    logic [pgtg_pkg::CFG_INDEX_W-1:0] reg_index;
    logic [pgtg_pkg::COLOR_W-1:0]     value;
    logic                             restart;
    table_entry_t                     want;
  } stim_row_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [pgtg_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [pgtg_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [15:0]                      s_tdata = '0;   // [14:0] base_color
  logic                             s_tuser = 1'b0; // [0] restart
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [23:0]                      m_tdata;        // [7:0] cgram_index, [22:8] color
  logic                             m_tuser;        // [0] is_restore
  logic                             m_tlast;

  // Shadow copies of the registers and of the table walk.
  logic [pgtg_pkg::INDEX_W-1:0]  cfg_palette_start;
  logic [pgtg_pkg::COUNT_W-1:0]  cfg_entry_count;
  logic [pgtg_pkg::COLOR_W-1:0]  cfg_target;
  logic [pgtg_pkg::ALPHA_W-1:0]  cfg_alpha;
  logic [pgtg_pkg::HEIGHT_W-1:0] cfg_height;
  logic [pgtg_pkg::HEIGHT_W-1:0] line_pos;
  logic [3:0]                    entry_ctr;
  table_phase_t                  tbl_phase;

  table_entry_t pending_entries[$];
  int           items_sent = 0;
  int           item_limit = 0;
  int           mismatch_count = 0;
  int           sender_idle_pct = 0;
  int           stall_pct = 0;
  bit           hold_request = 1'b0;

  stim_row_t directed_rows [35] = '{
    // Register defaults: the first position keeps the base color, the second
    // is still too far up the gradient for alpha 26 to move it.
    '{ROW_GIVEN,   '0, 15'h7FFF, 1'b1, '{8'd0,   15'h7FFF, 1'b0, 1'b0}},
    '{ROW_GIVEN,   '0, 15'h0000, 1'b0, '{8'd1,   15'h0000, 1'b0, 1'b0}},
    '{ROW_PREDICT, '0, 15'h2AAA, 1'b0, '0},
    // One-line table with a zero entry count that counts as one entry.
    '{ROW_WRITE, pgtg_pkg::REG_PALETTE_START,   15'd255,  1'b0, '0},
    '{ROW_WRITE, pgtg_pkg::REG_ENTRY_COUNT,     15'd0,    1'b0, '0},
    '{ROW_WRITE, pgtg_pkg::REG_TINT_COLOR,      15'h7FFF, 1'b0, '0},
    '{ROW_WRITE, pgtg_pkg::REG_BLEND_ALPHA,     15'd32,   1'b0, '0},
    '{ROW_WRITE, pgtg_pkg::REG_GRADIENT_HEIGHT, 15'd1,    1'b0, '0},
    '{ROW_GIVEN,   '0, 15'h0000, 1'b1, '{8'd255, 15'h0000, 1'b0, 1'b0}},
    '{ROW_GIVEN,   '0, 15'h1234, 1'b0, '{8'd255, 15'h1234, 1'b1, 1'b1}},
    '{ROW_SILENT,  '0, 15'h7FFF, 1'b0, '0},
    // Entry count and alpha above their ceilings, and a height too tall for a
    // restore pass to follow.
    '{ROW_WRITE, pgtg_pkg::REG_PALETTE_START,   15'd250,  1'b0, '0},
    '{ROW_WRITE, pgtg_pkg::REG_ENTRY_COUNT,     15'd31,   1'b0, '0},
    '{ROW_WRITE, pgtg_pkg::REG_BLEND_ALPHA,     15'd63,   1'b0, '0},
    '{ROW_WRITE, pgtg_pkg::REG_GRADIENT_HEIGHT, 15'd239,  1'b0, '0},
    '{ROW_PREDICT, '0, 15'h0000, 1'b1, '0},
    '{ROW_PREDICT, '0, 15'h7FFF, 1'b0, '0},
    '{ROW_PREDICT, '0, 15'h4210, 1'b0, '0},
    '{ROW_PREDICT, '0, 15'h001F, 1'b0, '0},
    // Height drops below the position: full weight on the target, then the
    // restore pass starts.
    '{ROW_WRITE, pgtg_pkg::REG_GRADIENT_HEIGHT, 15'd2,    1'b0, '0},
    '{ROW_GIVEN,   '0, 15'h0000, 1'b0, '{8'd254, 15'h7FFF, 1'b0, 1'b0}},
    '{ROW_GIVEN,   '0, 15'h0001, 1'b0, '{8'd250, 15'h0001, 1'b1, 1'b0}},
    '{ROW_GIVEN,   '0, 15'h4000, 1'b0, '{8'd251, 15'h4000, 1'b1, 1'b0}},
    '{ROW_GIVEN,   '0, 15'h03E0, 1'b0, '{8'd252, 15'h03E0, 1'b1, 1'b0}},
    // Entry count drops below the counter: this restore entry is the last.
    '{ROW_WRITE, pgtg_pkg::REG_ENTRY_COUNT,     15'd2,    1'b0, '0},
    '{ROW_GIVEN,   '0, 15'h7C00, 1'b0, '{8'd253, 15'h7C00, 1'b1, 1'b1}},
    '{ROW_SILENT,  '0, 15'h0000, 1'b0, '0},
    // Zero height: no blend entries, straight into the restore pass.
    '{ROW_WRITE, pgtg_pkg::REG_GRADIENT_HEIGHT, 15'd0,    1'b0, '0},
    '{ROW_WRITE, pgtg_pkg::REG_ENTRY_COUNT,     15'd1,    1'b0, '0},
    '{ROW_WRITE, pgtg_pkg::REG_PALETTE_START,   15'd128,  1'b0, '0},
    '{ROW_GIVEN,   '0, 15'h5A5A, 1'b1, '{8'd128, 15'h5A5A, 1'b1, 1'b1}},
    // Height right at the restore boundary, alpha zero.
    '{ROW_WRITE, pgtg_pkg::REG_GRADIENT_HEIGHT, 15'd222,  1'b0, '0},
    '{ROW_WRITE, pgtg_pkg::REG_BLEND_ALPHA,     15'd0,    1'b0, '0},
    '{ROW_PREDICT, '0, 15'h7FFF, 1'b1, '0},
    '{ROW_PREDICT, '0, 15'h1111, 1'b0, '0}
  };

  palette_gradient_table_generator_core #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Entry count as the block uses it: zero counts as one, large values clip.
  function automatic int active_entries();
    if (cfg_entry_count == 0) return 1;
    if (cfg_entry_count > MAX_ENTRIES) return MAX_ENTRIES;
    return int'(cfg_entry_count);
  endfunction

  function automatic bit restore_follows(int entries);
    return int'(cfg_height) < pgtg_pkg::RESTORE_LIMIT - entries;
  endfunction

  function automatic logic [pgtg_pkg::CH_W-1:0] mix_channel(
      logic [pgtg_pkg::CH_W-1:0] base_ch, logic [pgtg_pkg::CH_W-1:0] tgt_ch,
      int w_base, int w_tgt);
    int v;
    v = (int'(base_ch) * w_base + int'(tgt_ch) * w_tgt) >> pgtg_pkg::FRAC_W;
    if (v > int'(pgtg_pkg::CH_MAX)) v = int'(pgtg_pkg::CH_MAX);
    return v[pgtg_pkg::CH_W-1:0];
  endfunction

  // Advances the shadow table walk by one accepted item and returns 1 when
  // the item produces a table entry.
  function automatic bit step_gradient_table(input logic [pgtg_pkg::COLOR_W-1:0] base,
                                             input logic restart,
                                             output table_entry_t entry);
    int entries, diff, adj, alpha, w_tgt, w_base;
    logic [pgtg_pkg::CH_W-1:0] r, g, b;
    entries = active_entries();
    entry = '0;
    if (restart) begin
      line_pos = '0;
      entry_ctr = '0;
      tbl_phase = TBL_BLEND;
    end
    if (tbl_phase == TBL_BLEND && cfg_height == 0) begin
      entry_ctr = '0;
      tbl_phase = restore_follows(entries) ? TBL_RESTORE : TBL_DONE;
    end
    case (tbl_phase)
      TBL_BLEND: begin
        // The weight on the target grows as the position walks down.
        diff = (line_pos < cfg_height) ? int'(cfg_height) - int'(line_pos) : 0;
        adj = (diff << pgtg_pkg::FRAC_W) / int'(cfg_height);
        alpha = (cfg_alpha > pgtg_pkg::WEIGHT_ONE) ? int'(pgtg_pkg::WEIGHT_ONE)
                                                   : int'(cfg_alpha);
        w_tgt = ((int'(pgtg_pkg::WEIGHT_ONE) - adj) * alpha) >> pgtg_pkg::FRAC_W;
        w_base = int'(pgtg_pkg::WEIGHT_ONE) - w_tgt;
        r = mix_channel(base[0 +: pgtg_pkg::CH_W], cfg_target[0 +: pgtg_pkg::CH_W],
                        w_base, w_tgt);
        g = mix_channel(base[pgtg_pkg::CH_W +: pgtg_pkg::CH_W],
                        cfg_target[pgtg_pkg::CH_W +: pgtg_pkg::CH_W], w_base, w_tgt);
        b = mix_channel(base[2*pgtg_pkg::CH_W +: pgtg_pkg::CH_W],
                        cfg_target[2*pgtg_pkg::CH_W +: pgtg_pkg::CH_W], w_base, w_tgt);
        entry.cgram_index = cfg_palette_start + pgtg_pkg::INDEX_W'(entry_ctr);
        entry.color = {b, g, r};
        if (int'(line_pos) + 1 >= int'(cfg_height)) begin
          entry_ctr = '0;
          line_pos = '0;
          if (restore_follows(entries)) begin
            tbl_phase = TBL_RESTORE;
          end else begin
            tbl_phase = TBL_DONE;
            entry.last = 1'b1;
          end
        end else begin
          line_pos = line_pos + 1'b1;
          entry_ctr = (int'(entry_ctr) + 1 >= entries) ? '0 : entry_ctr + 1'b1;
        end
        return 1'b1;
      end
      TBL_RESTORE: begin
        entry.cgram_index = cfg_palette_start + pgtg_pkg::INDEX_W'(entry_ctr);
        entry.color = base;
        entry.is_restore = 1'b1;
        entry.last = (int'(entry_ctr) + 1 >= entries);
        if (entry.last) begin
          entry_ctr = '0;
          tbl_phase = TBL_DONE;
        end else begin
          entry_ctr = entry_ctr + 1'b1;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Picks a register value, a quarter of the time one of its extremes.
  // Heights stay small most of the time so that tables finish quickly.
  function automatic logic [pgtg_pkg::CFG_DATA_W-1:0] pick_value(
      logic [pgtg_pkg::CFG_INDEX_W-1:0] idx);
    int counts [4] = '{0, 1, 16, 31};
    int alphas [3] = '{0, 32, 63};
    int heights [8] = '{0, 1, 206, 207, 221, 222, 239, 255};
    bit extreme;
    int v;
    extreme = ($urandom_range(0, 3) == 0);
    v = 0;
    case (idx)
      pgtg_pkg::REG_PALETTE_START: begin
        if (extreme) v = $urandom_range(0, 1) * 255;
        else v = $urandom_range(0, 255);
      end
      pgtg_pkg::REG_ENTRY_COUNT: begin
        if (extreme) v = counts[$urandom_range(0, 3)];
        else v = $urandom_range(1, 16);
      end
      pgtg_pkg::REG_TINT_COLOR: begin
        if (extreme) v = $urandom_range(0, 1) * 32767;
        else v = $urandom_range(0, 32767);
      end
      pgtg_pkg::REG_BLEND_ALPHA: begin
        if (extreme) v = alphas[$urandom_range(0, 2)];
        else v = $urandom_range(0, 32);
      end
      pgtg_pkg::REG_GRADIENT_HEIGHT: begin
        if (extreme) v = heights[$urandom_range(0, 7)];
        else if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 255);
        else v = $urandom_range(1, 24);
      end
      default: v = 0;
    endcase
    return pgtg_pkg::CFG_DATA_W'(v);
  endfunction

  // Writes one register; cfg_valid stays high so that writes can follow
  // back to back, and the caller lowers it after the last one.
  task automatic write_reg(input logic [pgtg_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [pgtg_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      pgtg_pkg::REG_PALETTE_START:   cfg_palette_start = value[pgtg_pkg::INDEX_W-1:0];
      pgtg_pkg::REG_ENTRY_COUNT:     cfg_entry_count = value[pgtg_pkg::COUNT_W-1:0];
      pgtg_pkg::REG_TINT_COLOR:      cfg_target = value[pgtg_pkg::COLOR_W-1:0];
      pgtg_pkg::REG_BLEND_ALPHA:     cfg_alpha = value[pgtg_pkg::ALPHA_W-1:0];
      pgtg_pkg::REG_GRADIENT_HEIGHT: cfg_height = value[pgtg_pkg::HEIGHT_W-1:0];
      default: ;
    endcase
  endtask

  // Registers may only change while the block is quiet: every entry in,
  // then enough cycles for an item that produces nothing to finish.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offers one item after a random gap and returns the entry it should give.
  task automatic send_item(input logic [pgtg_pkg::COLOR_W-1:0] base, input logic restart,
                           output bit produced, output table_entry_t entry);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, base};
    s_tuser <= restart;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    produced = step_gradient_table(base, restart, entry);
  endtask

  // One walk through a table: usually a restart followed by enough items for
  // every blend and restore entry plus a couple of ignored ones; sometimes
  // cut short so that the next register change lands mid-table. The walk
  // also stops once the current phase has sent its share of items.
  task automatic run_table();
    int length;
    bit produced;
    table_entry_t entry;
    logic [pgtg_pkg::COLOR_W-1:0] base;
    logic restart;
    length = int'(cfg_height) + active_entries() + int'($urandom_range(0, 2));
    if ($urandom_range(0, 4) == 0) length = $urandom_range(1, length);
    for (int n = 0; (n < length) && (items_sent < item_limit); n++) begin
      base = pgtg_pkg::COLOR_W'($urandom_range(0, 32767));
      if ($urandom_range(0, 9) == 0) base = $urandom_range(0, 1) ? '1 : '0;
      restart = (n == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
      send_item(base, restart, produced, entry);
      if (produced) begin
        pending_entries.push_back(entry);
      end
    end
  endtask

  // Output side: random stalls per the current pattern, and once a long
  // hold-off so that the block backs up into its input.
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Every output transaction is matched against the oldest expected entry.
  always @(posedge clk) begin : result_check
    table_entry_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[pgtg_pkg::INDEX_W-1:0],
             m_tdata[pgtg_pkg::INDEX_W +: pgtg_pkg::COLOR_W], m_tuser, m_tlast};
      if (pending_entries.size() == 0) begin
        $error("unexpected entry: cgram_index %0d color %h is_restore %0b last %0b",
               got.cgram_index, got.color, got.is_restore, got.last);
        mismatch_count++;
      end else begin
        want = pending_entries.pop_front();
        if (got.cgram_index !== want.cgram_index) begin
          $error("cgram_index: expected %0d, got %0d", want.cgram_index, got.cgram_index);
          mismatch_count++;
        end
        if (got.color !== want.color) begin
          $error("color: expected %h, got %h", want.color, got.color);
          mismatch_count++;
        end
        if (got.is_restore !== want.is_restore) begin
          $error("is_restore: expected %0b, got %0b", want.is_restore, got.is_restore);
          mismatch_count++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, got.last);
          mismatch_count++;
        end
      end
    end
  end

  // Ends a hung run: counts cycles in which no transaction completes anywhere.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_palette_gradient_table_generator_core: FAIL");
    $finish;
  end

  initial begin : stimulus
    bit cfg_open;
    bit produced;
    bit wrote;
    table_entry_t predicted;
    int phase_no;
    cfg_palette_start = pgtg_pkg::RST_PALETTE_START;
    cfg_entry_count = pgtg_pkg::RST_ENTRY_COUNT;
    cfg_target = pgtg_pkg::RST_TINT_COLOR;
    cfg_alpha = pgtg_pkg::RST_BLEND_ALPHA;
    cfg_height = pgtg_pkg::RST_GRADIENT_HEIGHT;
    line_pos = '0;
    entry_ctr = '0;
    tbl_phase = TBL_BLEND;
    cfg_open = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed table, no idling on either side.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        if (!cfg_open) wait_idle();
        write_reg(directed_rows[i].reg_index, directed_rows[i].value);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) begin
          cfg_valid <= 1'b0;
          cfg_open = 1'b0;
        end
        send_item(directed_rows[i].value, directed_rows[i].restart, produced, predicted);
        if (directed_rows[i].kind == ROW_GIVEN) begin
          pending_entries.push_back(directed_rows[i].want);
        end else if (directed_rows[i].kind == ROW_PREDICT && produced) begin
          pending_entries.push_back(predicted);
        end
      end
    end

    // Random tables. Each phase rewrites a random set of registers, rotates
    // the idling pattern (none, sender idle, receiver stalling, both) and
    // sends an equal share of the random items.
    items_sent = 0;
    for (phase_no = 0; phase_no < PHASE_COUNT; phase_no++) begin
      wait_idle();
      case (phase_no % 4)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 88; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 88; end
        default: begin sender_idle_pct = 34; stall_pct = 34; end
      endcase
      wrote = 1'b0;
      for (int r = int'(pgtg_pkg::REG_PALETTE_START);
           r <= int'(pgtg_pkg::REG_GRADIENT_HEIGHT); r++) begin
        if ($urandom_range(0, 99) < 40) begin
          write_reg(pgtg_pkg::CFG_INDEX_W'(r), pick_value(pgtg_pkg::CFG_INDEX_W'(r)));
          wrote = 1'b1;
        end
      end
      if (wrote) cfg_valid <= 1'b0;
      // The first, no-idling phase holds the output off while items keep coming.
      if (phase_no == 0) hold_request = 1'b1;
      item_limit = ((phase_no + 1) * TARGET_ITEMS) / PHASE_COUNT;
      while (items_sent < item_limit) run_table();
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("tb_palette_gradient_table_generator_core: PASS");
    end else begin
      $display("tb_palette_gradient_table_generator_core: FAIL");
    end
    $finish;
  end

endmodule
